// ===== rtl/seg_pkg.sv =====
// shared types for the segment intersection pipeline
// no dependencies
`default_nettype none

package seg_pkg;

    // per-item classification carried down the divider stages
    typedef struct packed {
        logic hit;
        logic parallel;
        logic one_a;
        logic one_b;
    } seg_flags_t;

endpackage

`default_nettype wire

// ===== rtl/seg_div_stage.sv =====
// one restoring division step for both segment parameters, registered
// depends on seg_pkg
`default_nettype none

module seg_div_stage #(
    parameter int MAG_BITS  = 35,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_BITS = 66
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire seg_pkg::seg_flags_t     in_flags,
    input  wire logic [MAG_BITS-1:0]     in_den,
    input  wire logic [MAG_BITS-1:0]     in_rem_a,
    input  wire logic [MAG_BITS-1:0]     in_rem_b,
    input  wire logic [FRAC_BITS-1:0]    in_q_a,
    input  wire logic [FRAC_BITS-1:0]    in_q_b,
    input  wire logic [SIDE_BITS-1:0]    in_side,
    output logic                         out_valid,
    output seg_pkg::seg_flags_t          out_flags,
    output logic [MAG_BITS-1:0]          out_den,
    output logic [MAG_BITS-1:0]          out_rem_a,
    output logic [MAG_BITS-1:0]          out_rem_b,
    output logic [FRAC_BITS-1:0]         out_q_a,
    output logic [FRAC_BITS-1:0]         out_q_b,
    output logic [SIDE_BITS-1:0]         out_side
);
    import seg_pkg::*;

    logic [MAG_BITS:0]   sh_a;
    logic [MAG_BITS:0]   sh_b;
    logic [MAG_BITS:0]   dif_a;
    logic [MAG_BITS:0]   dif_b;
    logic                ge_a;
    logic                ge_b;
    logic [MAG_BITS-1:0] rem_a_next;
    logic [MAG_BITS-1:0] rem_b_next;
    logic                valid_reg;
    seg_flags_t          flags_reg;
    logic [MAG_BITS-1:0] den_reg;
    logic [MAG_BITS-1:0] rem_a_reg;
    logic [MAG_BITS-1:0] rem_b_reg;
    logic [FRAC_BITS-1:0] q_a_reg;
    logic [FRAC_BITS-1:0] q_b_reg;
    logic [SIDE_BITS-1:0] side_reg;

    // remainder stays below the divisor, so the doubled value fits one more bit
    always_comb
    begin
        sh_a  = {in_rem_a, 1'b0};
        sh_b  = {in_rem_b, 1'b0};
        dif_a = sh_a - {1'b0, in_den};
        dif_b = sh_b - {1'b0, in_den};
        ge_a  = sh_a >= {1'b0, in_den};
        ge_b  = sh_b >= {1'b0, in_den};
        rem_a_next = ge_a ? dif_a[MAG_BITS-1:0] : sh_a[MAG_BITS-1:0];
        rem_b_next = ge_b ? dif_b[MAG_BITS-1:0] : sh_b[MAG_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= in_flags;
            den_reg   <= in_den;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            q_a_reg   <= {in_q_a[FRAC_BITS-2:0], ge_a};
            q_b_reg   <= {in_q_b[FRAC_BITS-2:0], ge_b};
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_den   = den_reg;
    assign out_rem_a = rem_a_reg;
    assign out_rem_b = rem_b_reg;
    assign out_q_a   = q_a_reg;
    assign out_q_b   = q_b_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== rtl/segment_intersection_core.sv =====
// stages in order: differences, products, cross products, classification, divider steps, multiply, output
// throughput: one segment pair per cycle; each stage holds only while the
//   stage after it is full and stalled, so bubbles are squeezed out
// the FRAC_BITS restoring divider stages set the depth
// reset clears the valid bits only; data registers are not reset
// depends on seg_pkg and seg_div_stage
`default_nettype none

module segment_intersection_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] a_start_x,
    input  wire logic signed [COORD_BITS-1:0] a_start_y,
    input  wire logic signed [COORD_BITS-1:0] a_end_x,
    input  wire logic signed [COORD_BITS-1:0] a_end_y,
    input  wire logic signed [COORD_BITS-1:0] b_start_x,
    input  wire logic signed [COORD_BITS-1:0] b_start_y,
    input  wire logic signed [COORD_BITS-1:0] b_end_x,
    input  wire logic signed [COORD_BITS-1:0] b_end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              hit,
    output logic                              is_parallel,
    output logic [FRAC_BITS:0]                frac_a,
    output logic [FRAC_BITS:0]                frac_b,
    output logic signed [COORD_BITS-1:0]      point_x,
    output logic signed [COORD_BITS-1:0]      point_y
);
    import seg_pkg::*;

    localparam int D    = COORD_BITS + 1;
    localparam int PW   = 2 * D;
    localparam int P    = 2 * D + 1;
    localparam int NS   = FRAC_BITS + 6;
    localparam int M    = D + FRAC_BITS + 2;
    localparam int SW   = M - FRAC_BITS;
    localparam int SIDE = 2 * COORD_BITS + 2 * D;

    logic [NS-1:0] en;
    logic [NS-1:0] vld;

    // stage 0: differences
    logic signed [COORD_BITS-1:0] s0_x1_reg, s0_y1_reg;
    logic signed [D-1:0] s0_dxa_reg, s0_dya_reg, s0_dxb_reg, s0_dyb_reg, s0_ox_reg, s0_oy_reg;
    logic s0_v_reg;
    // stage 1: products
    logic signed [COORD_BITS-1:0] s1_x1_reg, s1_y1_reg;
    logic signed [D-1:0]  s1_dxa_reg, s1_dya_reg;
    logic signed [PW-1:0] s1_pd1_reg, s1_pd2_reg, s1_pa1_reg, s1_pa2_reg, s1_pb1_reg, s1_pb2_reg;
    logic s1_v_reg;
    // stage 2: cross products
    logic signed [COORD_BITS-1:0] s2_x1_reg, s2_y1_reg;
    logic signed [D-1:0] s2_dxa_reg, s2_dya_reg;
    logic signed [P-1:0] s2_den_reg, s2_na_reg, s2_nb_reg;
    logic s2_v_reg;
    // stage 3: classification
    logic [P-1:0] mag_den, mag_na, mag_nb;
    logic         par_c, ina_c, inb_c;
    seg_flags_t   s3_flags_reg;
    logic [P-1:0] s3_den_reg, s3_na_reg, s3_nb_reg;
    logic [SIDE-1:0] s3_side_reg;
    logic s3_v_reg;

    // divider chain
    logic                 dv    [FRAC_BITS+1];
    seg_flags_t           dflg  [FRAC_BITS+1];
    logic [P-1:0]         dden  [FRAC_BITS+1];
    logic [P-1:0]         drema [FRAC_BITS+1];
    logic [P-1:0]         dremb [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] dqa   [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] dqb   [FRAC_BITS+1];
    logic [SIDE-1:0]      dside [FRAC_BITS+1];

    // multiply stage
    logic [FRAC_BITS:0] fa_c, fb_c;
    logic signed [COORD_BITS-1:0] m_x1, m_y1;
    logic signed [D-1:0] m_dxa, m_dya;
    logic signed [M-1:0] sm_px_reg, sm_py_reg;
    logic [FRAC_BITS:0]  sm_fa_reg, sm_fb_reg;
    logic signed [COORD_BITS-1:0] sm_x1_reg, sm_y1_reg;
    seg_flags_t sm_flags_reg;
    logic sm_v_reg;

    // output stage
    logic signed [M-1:0]  tx, ty;
    logic signed [SW-1:0] sx, sy;
    logic signed [SW:0]   px, py;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic o_v_reg, o_hit_reg, o_par_reg;
    logic [FRAC_BITS:0] o_fa_reg, o_fb_reg;
    logic signed [COORD_BITS-1:0] o_px_reg, o_py_reg;

    localparam logic signed [SW:0] MAXV = (SW+1)'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [SW:0] MINV = -MAXV - (SW+1)'(1);
    localparam logic signed [M-1:0] HALF = M'(64'd1 << (FRAC_BITS - 1));

    // a stage may load when it is empty or its content moves on
    genvar gi;
    generate
        for (gi = 0; gi < NS - 1; gi++)
        begin : g_en
            assign en[gi] = !vld[gi] || en[gi+1];
        end
    endgenerate
    assign en[NS-1] = !vld[NS-1] || out_ready;
    assign in_ready = en[0];

    assign vld[0] = s0_v_reg;
    assign vld[1] = s1_v_reg;
    assign vld[2] = s2_v_reg;
    assign vld[3] = s3_v_reg;
    assign vld[NS-2] = sm_v_reg;
    assign vld[NS-1] = o_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (en[0])    s0_v_reg <= in_valid;
            if (en[1])    s1_v_reg <= s0_v_reg;
            if (en[2])    s2_v_reg <= s1_v_reg;
            if (en[3])    s3_v_reg <= s2_v_reg;
            if (en[NS-2]) sm_v_reg <= dv[FRAC_BITS];
            if (en[NS-1]) o_v_reg  <= sm_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_x1_reg  <= a_start_x;
            s0_y1_reg  <= a_start_y;
            s0_dxa_reg <= D'(a_end_x) - D'(a_start_x);
            s0_dya_reg <= D'(a_end_y) - D'(a_start_y);
            s0_dxb_reg <= D'(b_end_x) - D'(b_start_x);
            s0_dyb_reg <= D'(b_end_y) - D'(b_start_y);
            s0_ox_reg  <= D'(a_start_x) - D'(b_start_x);
            s0_oy_reg  <= D'(a_start_y) - D'(b_start_y);
        end
        if (en[1])
        begin
            s1_x1_reg  <= s0_x1_reg;
            s1_y1_reg  <= s0_y1_reg;
            s1_dxa_reg <= s0_dxa_reg;
            s1_dya_reg <= s0_dya_reg;
            s1_pd1_reg <= PW'(s0_dyb_reg) * PW'(s0_dxa_reg);
            s1_pd2_reg <= PW'(s0_dxb_reg) * PW'(s0_dya_reg);
            s1_pa1_reg <= PW'(s0_dxb_reg) * PW'(s0_oy_reg);
            s1_pa2_reg <= PW'(s0_dyb_reg) * PW'(s0_ox_reg);
            s1_pb1_reg <= PW'(s0_dxa_reg) * PW'(s0_oy_reg);
            s1_pb2_reg <= PW'(s0_dya_reg) * PW'(s0_ox_reg);
        end
        if (en[2])
        begin
            s2_x1_reg  <= s1_x1_reg;
            s2_y1_reg  <= s1_y1_reg;
            s2_dxa_reg <= s1_dxa_reg;
            s2_dya_reg <= s1_dya_reg;
            s2_den_reg <= P'(s1_pd1_reg) - P'(s1_pd2_reg);
            s2_na_reg  <= P'(s1_pa1_reg) - P'(s1_pa2_reg);
            s2_nb_reg  <= P'(s1_pb1_reg) - P'(s1_pb2_reg);
        end
    end

    // exact test of both parameters against the unit interval
    always_comb
    begin
        mag_den = s2_den_reg[P-1] ? P'(-s2_den_reg) : P'(s2_den_reg);
        mag_na  = s2_na_reg[P-1]  ? P'(-s2_na_reg)  : P'(s2_na_reg);
        mag_nb  = s2_nb_reg[P-1]  ? P'(-s2_nb_reg)  : P'(s2_nb_reg);
        par_c   = s2_den_reg == '0;
        ina_c   = (s2_na_reg == '0) ||
                  ((s2_na_reg[P-1] == s2_den_reg[P-1]) && (mag_na <= mag_den));
        inb_c   = (s2_nb_reg == '0) ||
                  ((s2_nb_reg[P-1] == s2_den_reg[P-1]) && (mag_nb <= mag_den));
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_flags_reg.hit      <= !par_c && ina_c && inb_c;
            s3_flags_reg.parallel <= par_c;
            s3_flags_reg.one_a    <= mag_na == mag_den;
            s3_flags_reg.one_b    <= mag_nb == mag_den;
            s3_den_reg  <= mag_den;
            s3_na_reg   <= mag_na;
            s3_nb_reg   <= mag_nb;
            s3_side_reg <= {s2_x1_reg, s2_y1_reg, s2_dxa_reg, s2_dya_reg};
        end
    end

    assign dv[0]    = s3_v_reg;
    assign dflg[0]  = s3_flags_reg;
    assign dden[0]  = s3_den_reg;
    assign drema[0] = s3_na_reg;
    assign dremb[0] = s3_nb_reg;
    assign dqa[0]   = '0;
    assign dqb[0]   = '0;
    assign dside[0] = s3_side_reg;

    generate
        for (gi = 0; gi < FRAC_BITS; gi++)
        begin : g_div
            seg_div_stage #(
                .MAG_BITS  (P),
                .FRAC_BITS (FRAC_BITS),
                .SIDE_BITS (SIDE)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en[4+gi]),
                .in_valid  (dv[gi]),
                .in_flags  (dflg[gi]),
                .in_den    (dden[gi]),
                .in_rem_a  (drema[gi]),
                .in_rem_b  (dremb[gi]),
                .in_q_a    (dqa[gi]),
                .in_q_b    (dqb[gi]),
                .in_side   (dside[gi]),
                .out_valid (dv[gi+1]),
                .out_flags (dflg[gi+1]),
                .out_den   (dden[gi+1]),
                .out_rem_a (drema[gi+1]),
                .out_rem_b (dremb[gi+1]),
                .out_q_a   (dqa[gi+1]),
                .out_q_b   (dqb[gi+1]),
                .out_side  (dside[gi+1])
            );
            assign vld[4+gi] = dv[gi+1];
        end
    endgenerate

    always_comb
    begin
        fa_c  = dflg[FRAC_BITS].one_a ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                      : {1'b0, dqa[FRAC_BITS]};
        fb_c  = dflg[FRAC_BITS].one_b ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                      : {1'b0, dqb[FRAC_BITS]};
        {m_x1, m_y1, m_dxa, m_dya} = dside[FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-2])
        begin
            sm_px_reg    <= M'(m_dxa) * $signed({1'b0, fa_c});
            sm_py_reg    <= M'(m_dya) * $signed({1'b0, fa_c});
            sm_fa_reg    <= fa_c;
            sm_fb_reg    <= fb_c;
            sm_x1_reg    <= m_x1;
            sm_y1_reg    <= m_y1;
            sm_flags_reg <= dflg[FRAC_BITS];
        end
    end

    // round half up is an arithmetic shift of the biased product
    always_comb
    begin
        tx = sm_px_reg + HALF;
        ty = sm_py_reg + HALF;
        sx = SW'(tx >>> FRAC_BITS);
        sy = SW'(ty >>> FRAC_BITS);
        px = (SW+1)'(sm_x1_reg) + (SW+1)'(sx);
        py = (SW+1)'(sm_y1_reg) + (SW+1)'(sy);
        if (px > MAXV)      cx = COORD_BITS'(MAXV);
        else if (px < MINV) cx = COORD_BITS'(MINV);
        else                cx = COORD_BITS'(px);
        if (py > MAXV)      cy = COORD_BITS'(MAXV);
        else if (py < MINV) cy = COORD_BITS'(MINV);
        else                cy = COORD_BITS'(py);
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            o_hit_reg <= sm_flags_reg.hit;
            o_par_reg <= sm_flags_reg.parallel;
            o_fa_reg  <= sm_flags_reg.hit ? sm_fa_reg : '0;
            o_fb_reg  <= sm_flags_reg.hit ? sm_fb_reg : '0;
            o_px_reg  <= sm_flags_reg.hit ? cx : '0;
            o_py_reg  <= sm_flags_reg.hit ? cy : '0;
        end
    end

    assign out_valid   = o_v_reg;
    assign hit         = o_hit_reg;
    assign is_parallel = o_par_reg;
    assign frac_a      = o_fa_reg;
    assign frac_b      = o_fb_reg;
    assign point_x     = o_px_reg;
    assign point_y     = o_py_reg;

endmodule

`default_nettype wire

// ===== rtl/seg_checker.sv =====
// port-level checks for segment_intersection_core, attached by bind
// no package dependencies
`default_nettype none

module seg_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  hit,
    input wire logic                  is_parallel,
    input wire logic [FRAC_BITS:0]    frac_a,
    input wire logic [FRAC_BITS:0]    frac_b,
    input wire logic [COORD_BITS-1:0] point_x,
    input wire logic [COORD_BITS-1:0] point_y
);

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frac_a) && $stable(point_x))
        else $error("stalled transaction changed");

    a_par_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_parallel |-> !hit)
        else $error("parallel segments reported a hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> frac_a == '0 && frac_b == '0 && point_x == '0 && point_y == '0)
        else $error("miss with nonzero payload");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> frac_a <= ONE && frac_b <= ONE)
        else $error("parameter above one");

endmodule

bind segment_intersection_core seg_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_seg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .is_parallel (is_parallel),
    .frac_a      (frac_a),
    .frac_b      (frac_b),
    .point_x     (point_x),
    .point_y     (point_y)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for segment_intersection_core: random and directed segment pairs
// checked against a behavioral intersection predictor in a small scoreboard
// depends on segment_intersection_core and the rtl it pulls in
`timescale 1ns / 100ps

module testbench;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LATENCY = FB + 6;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic              hit;
        logic              par;
        logic [FB:0]       fa;
        logic [FB:0]       fb;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } seg_result_t;

    typedef logic signed [CB-1:0] coord_t;

    class intersect_scoreboard;
        seg_result_t pending[$];
        int checked;
        int hits;
        int parallels;

        function longint unsigned div_frac(longint unsigned n, longint unsigned d);
            if (n == d)
                return longint'(1) << FB;
            return (n << FB) / d;
        endfunction

        function coord_t lerp(longint s, longint dlt, longint unsigned f);
            longint t;
            longint v;
            t = dlt * longint'(f) + (longint'(1) << (FB - 1));
            if (t >= 0)
                v = t >>> FB;
            else
                v = -(((-t) + (longint'(1) << FB) - 1) >>> FB);
            v = s + v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return coord_t'(v);
        endfunction

        // pairs fit in 64 bits: products are below 2^34 each
        function void note_pair(coord_t c[8]);
            seg_result_t r;
            longint dxa, dya, dxb, dyb, ox, oy, den, na, nb;
            longint unsigned ua, ub;
            dxa = longint'(c[2]) - c[0];
            dya = longint'(c[3]) - c[1];
            dxb = longint'(c[6]) - c[4];
            dyb = longint'(c[7]) - c[5];
            ox = longint'(c[0]) - c[4];
            oy = longint'(c[1]) - c[5];
            den = dyb * dxa - dxb * dya;
            na = dxb * oy - dyb * ox;
            nb = dxa * oy - dya * ox;
            r = '{default: '0};
            if (den == 0)
            begin
                r.par = 1'b1;
                parallels++;
            end
            else if ((na == 0 || ((na < 0) == (den < 0) && (na < 0 ? -na : na) <=
                     (den < 0 ? -den : den))) &&
                     (nb == 0 || ((nb < 0) == (den < 0) && (nb < 0 ? -nb : nb) <=
                     (den < 0 ? -den : den))))
            begin
                ua = div_frac(na < 0 ? -na : na, den < 0 ? -den : den);
                ub = div_frac(nb < 0 ? -nb : nb, den < 0 ? -den : den);
                r.hit = 1'b1;
                r.fa = ua[FB:0];
                r.fb = ub[FB:0];
                r.px = lerp(c[0], dxa, ua);
                r.py = lerp(c[1], dya, ua);
                hits++;
            end
            pending.push_back(r);
        endfunction

        task check_result(seg_result_t got);
            seg_result_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no pair outstanding");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.hit !== e.hit)
                report_mismatch($sformatf("hit %0b exp %0b", got.hit, e.hit));
            if (got.par !== e.par)
                report_mismatch($sformatf("is_parallel %0b exp %0b", got.par, e.par));
            if (got.fa !== e.fa)
                report_mismatch($sformatf("frac_a %0d exp %0d", got.fa, e.fa));
            if (got.fb !== e.fb)
                report_mismatch($sformatf("frac_b %0d exp %0d", got.fb, e.fb));
            if (got.px !== e.px)
                report_mismatch($sformatf("point_x %0d exp %0d", got.px, e.px));
            if (got.py !== e.py)
                report_mismatch($sformatf("point_y %0d exp %0d", got.py, e.py));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    coord_t a_start_x, a_start_y, a_end_x, a_end_y;
    coord_t b_start_x, b_start_y, b_end_x, b_end_y;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic is_parallel;
    logic [FB:0] frac_a;
    logic [FB:0] frac_b;
    coord_t point_x;
    coord_t point_y;

    intersect_scoreboard sb;
    int error_count;
    longint cycles;
    bit hold_out;
    int pairs_sent;

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        error_count++;
    endtask

    segment_intersection_core #(
        .COORD_BITS(CB),
        .FRAC_BITS(FB)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .a_start_x(a_start_x),
        .a_start_y(a_start_y),
        .a_end_x(a_end_x),
        .a_end_y(a_end_y),
        .b_start_x(b_start_x),
        .b_start_y(b_start_y),
        .b_end_x(b_end_x),
        .b_end_y(b_end_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit(hit),
        .is_parallel(is_parallel),
        .frac_a(frac_a),
        .frac_b(frac_b),
        .point_x(point_x),
        .point_y(point_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // one transaction on the input channel, valid stays up until accepted
    task automatic send_pair(coord_t c[8]);
        in_valid <= 1'b1;
        a_start_x <= c[0];
        a_start_y <= c[1];
        a_end_x <= c[2];
        a_end_y <= c[3];
        b_start_x <= c[4];
        b_start_y <= c[5];
        b_end_x <= c[6];
        b_end_y <= c[7];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pair(c);
        pairs_sent++;
    endtask

    task automatic idle_input(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2000) - 1000);
            default: return coord_t'($urandom_range(0, 64) - 32);
        endcase
    endfunction

    // random pair; some shapes are forced to cross or touch so hits are common
    task automatic random_pair(output coord_t c[8]);
        int mode;
        int shape;
        mode = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        foreach (c[i])
            c[i] = rand_coord(mode);
        if (shape == 0)
        begin
            // collinear or parallel: B is A shifted
            c[4] = c[0] + coord_t'(mode == 0 ? 0 : 5);
            c[5] = c[1];
            c[6] = c[2] + coord_t'(mode == 0 ? 0 : 5);
            c[7] = c[3];
        end
        else if (shape == 1)
        begin
            // B starts on A's start: a parameter is exactly zero
            c[4] = c[0];
            c[5] = c[1];
        end
        else if (shape == 2)
        begin
            c[6] = c[2];
            c[7] = c[3];
        end
        else if (shape < 7 && mode != 0)
        begin
            // endpoints on opposite sides of the origin area
            c[2] = -c[0];
            c[3] = -c[1];
            c[6] = -c[4];
            c[7] = -c[5];
        end
    endtask

    initial
    begin
        coord_t c[8];
        coord_t ext[4];
        sb = new();
        error_count = 0;
        pairs_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_start_x, a_start_y, a_end_x, a_end_y} = '0;
        {b_start_x, b_start_y, b_end_x, b_end_y} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, crosses, touching ends, degenerate and parallel
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        c = '{-160, 0, 160, 0, 0, -160, 0, 160};
        send_pair(c);
        c = '{0, 0, 160, 0, 160, 0, 160, 160};
        send_pair(c);
        c = '{0, 0, 160, 160, 0, 160, 160, 0};
        send_pair(c);
        c = '{0, 0, 0, 0, 5, 5, 9, 9};
        send_pair(c);
        c = '{0, 0, 10, 10, 20, 20, 30, 30};
        send_pair(c);
        c = '{0, 0, 10, 0, 0, 1, 10, 1};
        send_pair(c);
        c = '{0, 0, 10, 0, 20, -5, 20, 5};
        send_pair(c);
        c = '{0, 0, 3, 1, 1, 0, 0, 3};
        send_pair(c);
        c = '{-3, -1, 0, 0, 0, 0, -1, -3};
        send_pair(c);
        c = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        send_pair(c);
        c = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        send_pair(c);
        for (int k = 0; k < 12; k++)
        begin
            foreach (c[i])
                c[i] = ext[$urandom_range(0, 3)];
            send_pair(c);
        end

        for (int n = 0; n < 1300; n++)
        begin
            random_pair(c);
            send_pair(c);
            // drain once mid-run so the pipe empties with the sender quiet
            if (n == 650)
            begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            else
                idle_input(gap_len());
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("sent %0d segment pairs, checked %0d results", pairs_sent, sb.checked);
        $display("%0d hits and %0d parallel or degenerate pairs seen", sb.hits,
                 sb.parallels);
        if (error_count == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        hold_out = 1'b0;
        wait (pairs_sent >= 200);
        @(posedge clk);
        hold_out <= 1'b1;
        repeat (LATENCY * 4) @(posedge clk);
        hold_out <= 1'b0;
    end

    // output side: random stalls, checks on accepted transactions
    initial
    begin
        seg_result_t got;
        int wait_n;
        out_ready = 1'b0;
        wait_n = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.hit = hit;
                got.par = is_parallel;
                got.fa = frac_a;
                got.fb = frac_b;
                got.px = point_x;
                got.py = point_y;
                sb.check_result(got);
            end
            if (hold_out)
                out_ready <= 1'b0;
            else if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                wait_n--;
            end
            else
            begin
                out_ready <= 1'b1;
                // stretches with no stall in between
                wait_n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
